// ===== design/dnsa_pkg.sv =====
package dnsa_pkg;

   localparam int MAX_MESSAGE_BYTES = 1024;
   localparam int NAME_LABEL_LIMIT  = 128;

   localparam int OFFSET_WIDTH      = $clog2(MAX_MESSAGE_BYTES + 1);
   localparam int LABEL_COUNT_WIDTH = $clog2(NAME_LABEL_LIMIT + 1);

   localparam int HEADER_BYTES      = 12;
   localparam int QFIXED_BYTES      = 4;
   localparam int AFIXED_BYTES      = 10;
   localparam int A_RDATA_BYTES     = 4;
   localparam int MAX_LABEL_LENGTH  = 63;

   localparam logic [15:0] TYPE_A   = 16'd1;
   localparam logic [15:0] CLASS_IN = 16'd1;
   localparam logic [1:0]  PTR_MARK = 2'b11;

   typedef enum logic [3:0] {
      PH_HEADER = 4'd0,
      PH_QNAME  = 4'd1,
      PH_QPTR   = 4'd2,
      PH_QFIXED = 4'd3,
      PH_ANAME  = 4'd4,
      PH_APTR   = 4'd5,
      PH_AFIXED = 4'd6,
      PH_ASKIP  = 4'd7,
      PH_AMATCH = 4'd8,
      PH_DONE   = 4'd9
   } phase_type;

   typedef enum logic [1:0] {
      ST_FOUND = 2'd0,
      ST_NONE  = 2'd1,
      ST_BAD   = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       last_byte;
   } item_type;

   typedef struct packed {
      logic        valid;
      status_type  status;
      logic [31:0] address;
   } result_type;

endpackage

// ===== design/dns_answer_a_record_extractor.sv =====
// DNS answer A-record extractor.
//
// req channel: one word per message byte. req_tdata[7:0] is the byte,
// req_tlast marks the final byte of the message. rsp channel: one word per
// message, giving status (0 found, 1 no matching A record, 2 malformed or
// truncated) and the IPv4 address, first data byte in the top bits.
//
// Words pass through an input register, one step of the parser logic and an
// output register. A result is registered in the output register by the parser
// step on the byte that decides it (or the last byte of a truncated message),
// after that byte has passed through the input register.
// Throughput is one byte per cycle, set by the single-pass parser step; the
// input register takes a new word while a result waits in the output
// register, and the parser only stalls once both registers hold data and
// rsp_tready is low; req_tready is low exactly while that holds.
//
// Reset (synchronous, active high) empties both registers and returns the
// parser to the start of a message. After the last byte of a message the
// parser is back at the start as well, so messages may follow back to back.
module dns_answer_a_record_extractor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_value
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // [1:0] status, [33:2] address, [39:34] zero
);
   import dnsa_pkg::*;

   logic       in_valid_ff, in_valid_in;
   item_type   in_item_ff;
   logic       process;

   logic        rsp_valid_ff, rsp_valid_in;
   status_type  rsp_status_ff;
   logic [31:0] rsp_address_ff;

   result_type result;

   // parser advances when the output register can take whatever it emits
   assign process    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || process;

   assign in_valid_in  = (req_tvalid && req_tready) ? 1'b1 :
                         (process ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = (process && result.valid) ? 1'b1 :
                         (rsp_tready ? 1'b0 : rsp_valid_ff);

   dnsa_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .step   (process),
      .item   (in_item_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff.byte_value <= req_tdata;
         in_item_ff.last_byte  <= req_tlast;
      end
      if (process && result.valid) begin
         rsp_status_ff  <= result.status;
         rsp_address_ff <= result.address;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_address_ff, rsp_status_ff};

endmodule

// ===== design/dnsa_parser.sv =====
module dnsa_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  dnsa_pkg::item_type  item,
   output dnsa_pkg::result_type result
);
   import dnsa_pkg::*;

   logic [OFFSET_WIDTH-1:0]      offset_ff, offset_in;
   logic [15:0]                  qcount_ff, qcount_in;
   logic [15:0]                  acount_ff, acount_in;
   phase_type                    phase_ff, phase_in;
   logic [5:0]                   label_left_ff, label_left_in;
   logic [LABEL_COUNT_WIDTH-1:0] labels_ff, labels_in;
   logic [3:0]                   field_ff, field_in;
   logic [15:0]                  rtype_ff, rtype_in;
   logic [15:0]                  rclass_ff, rclass_in;
   logic [15:0]                  data_left_ff, data_left_in;
   logic [31:0]                  acc_ff, acc_in;
   logic                         given_ff, given_in;

   logic       hit;
   status_type st;
   logic       go_answers;
   logic       is_name;
   phase_type  ptr_phase;
   phase_type  fixed_phase;
   logic [7:0] b;
   logic [3:0] field_next;
   logic [15:0] rdlen;

   assign b = item.byte_value;

   always_comb begin
      offset_in     = offset_ff;
      qcount_in     = qcount_ff;
      acount_in     = acount_ff;
      phase_in      = phase_ff;
      label_left_in = label_left_ff;
      labels_in     = labels_ff;
      field_in      = field_ff;
      rtype_in      = rtype_ff;
      rclass_in     = rclass_ff;
      data_left_in  = data_left_ff;
      acc_in        = acc_ff;
      given_in      = given_ff;
      hit           = 1'b0;
      st            = ST_BAD;
      go_answers    = 1'b0;
      is_name       = 1'b0;
      ptr_phase     = PH_QPTR;
      fixed_phase   = PH_QFIXED;
      field_next    = field_ff + 4'd1;
      rdlen         = {data_left_ff[15:8], b};
      result        = '0;

      if (step) begin
         if (offset_ff < OFFSET_WIDTH'(MAX_MESSAGE_BYTES)) begin
            if (!given_ff) begin
               case (phase_ff)
                  PH_HEADER: begin
                     case (offset_ff)
                        OFFSET_WIDTH'(4): qcount_in = {b, 8'd0};
                        OFFSET_WIDTH'(5): qcount_in = {qcount_ff[15:8], b};
                        OFFSET_WIDTH'(6): acount_in = {b, 8'd0};
                        OFFSET_WIDTH'(7): acount_in = {acount_ff[15:8], b};
                        OFFSET_WIDTH'(HEADER_BYTES - 1): begin
                           if (qcount_ff != 16'd0) begin
                              phase_in      = PH_QNAME;
                              label_left_in = '0;
                              labels_in     = '0;
                              field_in      = '0;
                           end else begin
                              go_answers = 1'b1;
                           end
                        end
                        default: ;
                     endcase
                  end
                  PH_QNAME: begin
                     is_name = 1'b1;
                  end
                  PH_ANAME: begin
                     is_name     = 1'b1;
                     ptr_phase   = PH_APTR;
                     fixed_phase = PH_AFIXED;
                  end
                  PH_QPTR: begin
                     phase_in = PH_QFIXED;
                     field_in = '0;
                  end
                  PH_APTR: begin
                     phase_in = PH_AFIXED;
                     field_in = '0;
                  end
                  PH_QFIXED: begin
                     field_in = field_next;
                     if (field_next >= 4'(QFIXED_BYTES)) begin
                        qcount_in = qcount_ff - 16'd1;
                        if (qcount_in != 16'd0) begin
                           phase_in      = PH_QNAME;
                           label_left_in = '0;
                           labels_in     = '0;
                           field_in      = '0;
                        end else begin
                           go_answers = 1'b1;
                        end
                     end
                  end
                  PH_AFIXED: begin
                     case (field_ff)
                        4'd0: rtype_in = {b, 8'd0};
                        4'd1: rtype_in = {rtype_ff[15:8], b};
                        4'd2: rclass_in = {b, 8'd0};
                        4'd3: rclass_in = {rclass_ff[15:8], b};
                        4'd8: data_left_in = {b, 8'd0};
                        4'd9: data_left_in = rdlen;
                        default: ;
                     endcase
                     field_in = field_next;
                     if (field_next >= 4'(AFIXED_BYTES)) begin
                        // type and class are complete; length completes on this byte
                        if (rtype_ff == TYPE_A && rclass_ff == CLASS_IN &&
                            rdlen == 16'(A_RDATA_BYTES)) begin
                           phase_in = PH_AMATCH;
                           acc_in   = '0;
                        end else if (rdlen == 16'd0) begin
                           acount_in  = acount_ff - 16'd1;
                           go_answers = 1'b1;
                        end else begin
                           phase_in = PH_ASKIP;
                        end
                     end
                  end
                  PH_ASKIP: begin
                     data_left_in = data_left_ff - 16'd1;
                     if (data_left_in == 16'd0) begin
                        acount_in  = acount_ff - 16'd1;
                        go_answers = 1'b1;
                     end
                  end
                  PH_AMATCH: begin
                     acc_in       = {acc_ff[23:0], b};
                     data_left_in = data_left_ff - 16'd1;
                     if (data_left_in == 16'd0) begin
                        hit = 1'b1;
                        st  = ST_FOUND;
                     end
                  end
                  default: ;
               endcase

               // name walk: label bodies are skipped, length bytes are checked
               if (is_name) begin
                  if (label_left_ff != 6'd0) begin
                     label_left_in = label_left_ff - 6'd1;
                  end else if (labels_ff >= LABEL_COUNT_WIDTH'(NAME_LABEL_LIMIT)) begin
                     hit = 1'b1;
                     st  = ST_BAD;
                  end else begin
                     labels_in = labels_ff + LABEL_COUNT_WIDTH'(1);
                     if (b == 8'd0) begin
                        phase_in = fixed_phase;
                        field_in = '0;
                     end else if (b[7:6] == PTR_MARK) begin
                        phase_in = ptr_phase;
                     end else if (b > 8'(MAX_LABEL_LENGTH)) begin
                        hit = 1'b1;
                        st  = ST_BAD;
                     end else begin
                        label_left_in = b[5:0];
                     end
                  end
               end

               if (go_answers) begin
                  if (acount_in == 16'd0) begin
                     hit = 1'b1;
                     st  = ST_NONE;
                  end else begin
                     phase_in      = PH_ANAME;
                     label_left_in = '0;
                     labels_in     = '0;
                     field_in      = '0;
                  end
               end
            end
            offset_in = offset_ff + OFFSET_WIDTH'(1);
            if (hit) begin
               given_in = 1'b1;
               phase_in = PH_DONE;
            end
         end

         result.valid   = hit;
         result.status  = st;
         result.address = (hit && st == ST_FOUND) ? acc_in : 32'd0;

         if (item.last_byte) begin
            if (!hit && !given_ff) begin
               result.valid   = 1'b1;
               result.status  = ST_BAD;
               result.address = 32'd0;
            end
            offset_in     = '0;
            qcount_in     = '0;
            acount_in     = '0;
            phase_in      = PH_HEADER;
            label_left_in = '0;
            labels_in     = '0;
            field_in      = '0;
            rtype_in      = '0;
            rclass_in     = '0;
            data_left_in  = '0;
            acc_in        = '0;
            given_in      = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff     <= '0;
         qcount_ff     <= '0;
         acount_ff     <= '0;
         phase_ff      <= PH_HEADER;
         label_left_ff <= '0;
         labels_ff     <= '0;
         field_ff      <= '0;
         rtype_ff      <= '0;
         rclass_ff     <= '0;
         data_left_ff  <= '0;
         acc_ff        <= '0;
         given_ff      <= 1'b0;
      end else begin
         offset_ff     <= offset_in;
         qcount_ff     <= qcount_in;
         acount_ff     <= acount_in;
         phase_ff      <= phase_in;
         label_left_ff <= label_left_in;
         labels_ff     <= labels_in;
         field_ff      <= field_in;
         rtype_ff      <= rtype_in;
         rclass_ff     <= rclass_in;
         data_left_ff  <= data_left_in;
         acc_ff        <= acc_in;
         given_ff      <= given_in;
      end
   end

   // a given result parks the parser until the message ends
   a_given_done: assert property (@(posedge clock) disable iff (reset)
      given_ff |-> phase_ff == PH_DONE)
      else $error("result flag set outside done phase");

   // label body bytes are only pending inside a name
   a_label_in_name: assert property (@(posedge clock) disable iff (reset)
      label_left_ff != 6'd0 |-> (phase_ff == PH_QNAME || phase_ff == PH_ANAME))
      else $error("label bytes pending outside a name");

   a_label_limit: assert property (@(posedge clock) disable iff (reset)
      labels_ff <= LABEL_COUNT_WIDTH'(NAME_LABEL_LIMIT))
      else $error("label count past limit");

   a_match_len: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_AMATCH |-> (data_left_ff != 16'd0 &&
                                 data_left_ff <= 16'(A_RDATA_BYTES)))
      else $error("address bytes out of range");

   // a result on a non-final word must leave the parser done
   a_result_parks: assert property (@(posedge clock) disable iff (reset)
      step && result.valid && !item.last_byte |=> phase_ff == PH_DONE)
      else $error("parser kept running after a result");

endmodule
